// ===== hw/rtl/usb_printer_interface_finder_macros.svh =====
// Assertion macros shared by the printer interface finder RTL.
`ifndef USB_PRINTER_INTERFACE_FINDER_MACROS_SVH
`define USB_PRINTER_INTERFACE_FINDER_MACROS_SVH

`ifndef ASSERT_OFF
`define USBPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define USBPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define USBPF_ASSERT(label, clk, rst, prop, msg)
`define USBPF_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/usbpf_pkg.sv =====
// Types and constants of the USB printer interface finder.
`timescale 1ns / 1ps
package usbpf_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int TOTAL_BITS          = 16;
   localparam int CMP_BITS            = TOTAL_BITS + 1;
   localparam int PKT_BITS            = 11;

   localparam logic [7:0] DESC_INTERFACE   = 8'd4;
   localparam logic [7:0] DESC_ENDPOINT    = 8'd5;
   localparam logic [7:0] IFACE_MIN_LEN    = 8'd9;
   localparam logic [7:0] EP_MIN_LEN       = 8'd7;
   localparam logic [7:0] DESC_MIN_LEN     = 8'd2;
   localparam logic [7:0] CLASS_PRINTER    = 8'd7;
   localparam logic [7:0] SUBCLASS_PRINTER = 8'd1;
   localparam logic [7:0] PROTO_UNIDIR     = 8'd1;
   localparam logic [7:0] PROTO_BIDIR      = 8'd2;
   localparam logic [1:0] XFER_BULK        = 2'd2;
   localparam int         EP_DIR_BIT       = 7;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NONE      = 2'd1,
      STATUS_MALFORMED = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]          iface;
      logic [7:0]          alt;
      logic [1:0]          proto;
      logic [7:0]          out_ep;
      logic [PKT_BITS-1:0] out_size;
      logic [7:0]          in_ep;
      logic [PKT_BITS-1:0] in_size;
   } cand_type;

   typedef struct packed {
      status_type status;
      cand_type   cand;
   } result_type;

endpackage

// ===== hw/rtl/usb_printer_interface_finder.sv =====
// Top level of the USB printer interface finder: item registers and handshakes.
`timescale 1ns / 1ps
`include "usb_printer_interface_finder_macros.svh"
// Finds a printer class interface with a bulk OUT endpoint in a USB
// configuration descriptor set fed one byte per item.
// req channel: req_data_byte is the next byte of the set; req_last marks the
//   final byte. Every byte is accepted; only the last one produces a result.
// rsp channel: one result per set: rsp_status (found, none, malformed) and
//   the interface number, alternate setting, protocol and bulk endpoints,
//   all zero unless an interface was found.
// Timing: an accepted byte is registered and parsed in the following cycle
//   unless it is a last byte held by a stall; the result for a last byte is
//   loaded into the result register at the end of that parse. One byte per
//   cycle is sustained while no last byte stalls, set by the single parse
//   step between the input register and the result register.
// Stall: while a result waits on rsp_ready, ordinary bytes keep flowing; a
//   following last byte holds in the input register until the result is
//   taken, and req_ready drops behind it.
// Reset: synchronous, active high; clears the parse state and the valid bits
//   of both registers. The parse state also returns to reset after each last byte.
module usb_printer_interface_finder #(
   parameter int LENGTH_BITS = usbpf_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [7:0]                     rsp_iface_num,
   output logic [7:0]                     rsp_alt_setting,
   output logic [1:0]                     rsp_protocol,
   output logic [7:0]                     rsp_out_endpoint,
   output logic [usbpf_pkg::PKT_BITS-1:0] rsp_out_packet_size,
   output logic [7:0]                     rsp_in_endpoint,
   output logic [usbpf_pkg::PKT_BITS-1:0] rsp_in_packet_size
);
   import usbpf_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   result_type core_result;
   logic       out_free;
   logic       advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;

   usbpf_core #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .result    (core_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_last_in  = req_last;
      end
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      // Load the result register when a last byte is parsed.
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_iface_num       = rsp_ff.cand.iface;
   assign rsp_alt_setting     = rsp_ff.cand.alt;
   assign rsp_protocol        = rsp_ff.cand.proto;
   assign rsp_out_endpoint    = rsp_ff.cand.out_ep;
   assign rsp_out_packet_size = rsp_ff.cand.out_size;
   assign rsp_in_endpoint     = rsp_ff.cand.in_ep;
   assign rsp_in_packet_size  = rsp_ff.cand.in_size;

   `USBPF_ASSERT_IMP(a_last_gives_result, clock, reset, advance && in_last_ff,
      ##1 rsp_valid, "parsed last byte did not produce a result")
   `USBPF_ASSERT_IMP(a_found_has_out_ep, clock, reset,
      rsp_valid && rsp_status == STATUS_FOUND,
      rsp_out_endpoint != '0 && rsp_out_packet_size != '0,
      "found result without bulk OUT endpoint")
   `USBPF_ASSERT_IMP(a_not_found_zero, clock, reset,
      rsp_valid && rsp_status != STATUS_FOUND,
      rsp_iface_num == '0 && rsp_out_endpoint == '0 && rsp_in_endpoint == '0 &&
      rsp_protocol == '0, "fields not zero without a found interface")
   `USBPF_ASSERT(a_no_overwrite, clock, reset,
      rsp_valid && !rsp_ready |-> !(advance && in_last_ff), "pending result overwritten")

endmodule

// ===== hw/rtl/usbpf_core.sv =====
// Descriptor parsing state and per-byte update of the printer interface finder.
`timescale 1ns / 1ps
module usbpf_core #(
   parameter int LENGTH_BITS = usbpf_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   last,
   output usbpf_pkg::result_type  result
);
   import usbpf_pkg::*;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
   localparam int XB = CMP_BITS - LENGTH_BITS;

   logic [LENGTH_BITS-1:0] offset_ff, offset_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic [LENGTH_BITS-1:0] start_ff, start_in;
   logic [7:0]             length_ff, length_in;
   logic [7:0]             kind_ff, kind_in;
   logic                   matching_ff, matching_in;
   logic                   class_ok_ff, class_ok_in;
   logic                   ep_bulk_ff, ep_bulk_in;
   logic [7:0]             ep_addr_ff, ep_addr_in;
   logic [7:0]             pkt_low_ff, pkt_low_in;
   cand_type               cand_ff, cand_in;
   logic                   stopped_ff, stopped_in;
   logic                   malformed_ff, malformed_in;

   // Returns {stop, malformed} for a descriptor at s of length len.
   function automatic logic [1:0] check_start(input logic [LENGTH_BITS-1:0] s,
                                              input logic [LENGTH_BITS-1:0] len,
                                              input logic [TOTAL_BITS-1:0]  total);
      logic [CMP_BITS-1:0] s_x;
      logic [CMP_BITS-1:0] t_x;
      s_x = {{XB{1'b0}}, s};
      t_x = {1'b0, total};
      if (s_x + CMP_BITS'(2) > t_x)
         return 2'b10;
      else if (len < LENGTH_BITS'(DESC_MIN_LEN) || s_x + {{XB{1'b0}}, len} > t_x)
         return 2'b01;
      else
         return 2'b00;
   endfunction

   always_comb begin
      logic [LENGTH_BITS-1:0] o;
      logic [LENGTH_BITS-1:0] rel;
      logic [LENGTH_BITS-1:0] first_len;
      logic [CMP_BITS-1:0]    desc_end;
      logic                   begin_desc;
      logic                   complete;
      logic [1:0]             chk;
      logic [PKT_BITS-1:0]    mps;

      offset_in    = offset_ff;
      total_in     = total_ff;
      start_in     = start_ff;
      length_in    = length_ff;
      kind_in      = kind_ff;
      matching_in  = matching_ff;
      class_ok_in  = class_ok_ff;
      ep_bulk_in   = ep_bulk_ff;
      ep_addr_in   = ep_addr_ff;
      pkt_low_in   = pkt_low_ff;
      cand_in      = cand_ff;
      stopped_in   = stopped_ff;
      malformed_in = malformed_ff;
      result       = '0;

      o          = offset_ff;
      rel        = o - start_ff;
      desc_end   = {{XB{1'b0}}, start_ff} + {{(CMP_BITS-8){1'b0}}, length_ff};
      begin_desc = (o == '0) ||
                   (length_ff >= DESC_MIN_LEN && {{XB{1'b0}}, o} == desc_end);
      first_len  = '0;
      chk        = '0;
      mps        = {data_byte[2:0], pkt_low_ff};
      complete   = 1'b0;

      if (step) begin
         if (!stopped_ff && !malformed_ff) begin
            if (o == LENGTH_BITS'(2)) total_in[7:0]  = data_byte;
            if (o == LENGTH_BITS'(3)) total_in[15:8] = data_byte;
            if (begin_desc) begin
               start_in  = o;
               length_in = data_byte;
               kind_in   = '0;
               if (o >= LENGTH_BITS'(4)) begin
                  chk = check_start(o, LENGTH_BITS'(data_byte), total_in);
               end
            end else if (rel == LENGTH_BITS'(1)) begin
               kind_in = data_byte;
               if (data_byte == DESC_INTERFACE && length_ff >= IFACE_MIN_LEN) begin
                  if (matching_ff && cand_ff.out_ep != '0 && cand_ff.out_size != '0) begin
                     stopped_in = 1'b1;
                  end else begin
                     matching_in = 1'b0;
                     class_ok_in = 1'b0;
                     cand_in     = '0;
                  end
               end
            end else if (rel >= LENGTH_BITS'(2)) begin
               if (kind_ff == DESC_INTERFACE && length_ff >= IFACE_MIN_LEN) begin
                  case (rel)
                     LENGTH_BITS'(2): cand_in.iface = data_byte;
                     LENGTH_BITS'(3): cand_in.alt   = data_byte;
                     LENGTH_BITS'(5): class_ok_in   = (data_byte == CLASS_PRINTER);
                     LENGTH_BITS'(6): class_ok_in   = class_ok_ff &&
                                                      (data_byte == SUBCLASS_PRINTER);
                     LENGTH_BITS'(7): begin
                        cand_in.proto = data_byte[1:0];
                        matching_in   = class_ok_ff && (data_byte == PROTO_UNIDIR ||
                                                        data_byte == PROTO_BIDIR);
                     end
                     default: ;
                  endcase
               end else if (kind_ff == DESC_ENDPOINT && length_ff >= EP_MIN_LEN &&
                            matching_ff) begin
                  case (rel)
                     LENGTH_BITS'(2): ep_addr_in = data_byte;
                     LENGTH_BITS'(3): ep_bulk_in = (data_byte[1:0] == XFER_BULK);
                     LENGTH_BITS'(4): pkt_low_in = data_byte;
                     LENGTH_BITS'(5): begin
                        if (ep_bulk_ff) begin
                           if (ep_addr_ff[EP_DIR_BIT]) begin
                              cand_in.in_ep   = ep_addr_ff;
                              cand_in.in_size = mps;
                           end else begin
                              cand_in.out_ep   = ep_addr_ff;
                              cand_in.out_size = mps;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            stopped_in   = stopped_in | chk[1];
            malformed_in = malformed_in | chk[0];

            // Descriptors that began before the total was known get checked now.
            if (o == LENGTH_BITS'(3) && !stopped_in && !malformed_in) begin
               first_len = (start_in == '0) ? LENGTH_BITS'(length_in) : start_in;
               chk = check_start('0, first_len, total_in);
               stopped_in   = stopped_in | chk[1];
               malformed_in = malformed_in | chk[0];
               if (!stopped_in && !malformed_in && start_in != '0) begin
                  chk = check_start(start_in, LENGTH_BITS'(length_in), total_in);
                  stopped_in   = stopped_in | chk[1];
                  malformed_in = malformed_in | chk[0];
               end
            end
         end

         if (offset_ff != LEN_MAX) offset_in = offset_ff + LENGTH_BITS'(1);

         if (last) begin
            complete = matching_in && cand_in.out_ep != '0 && cand_in.out_size != '0;
            if (malformed_in || offset_in < LENGTH_BITS'(4) ||
                {{XB{1'b0}}, offset_in} < {1'b0, total_in}) begin
               result.status = STATUS_MALFORMED;
            end else if (complete) begin
               result.status = STATUS_FOUND;
               result.cand   = cand_in;
            end else begin
               result.status = STATUS_NONE;
            end
            // Return to the reset state for the next descriptor set.
            offset_in    = '0;
            total_in     = '0;
            start_in     = '0;
            length_in    = '0;
            kind_in      = '0;
            matching_in  = 1'b0;
            class_ok_in  = 1'b0;
            ep_bulk_in   = 1'b0;
            ep_addr_in   = '0;
            pkt_low_in   = '0;
            cand_in      = '0;
            stopped_in   = 1'b0;
            malformed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         total_ff     <= '0;
         start_ff     <= '0;
         length_ff    <= '0;
         kind_ff      <= '0;
         matching_ff  <= 1'b0;
         class_ok_ff  <= 1'b0;
         ep_bulk_ff   <= 1'b0;
         ep_addr_ff   <= '0;
         pkt_low_ff   <= '0;
         cand_ff      <= '0;
         stopped_ff   <= 1'b0;
         malformed_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         total_ff     <= total_in;
         start_ff     <= start_in;
         length_ff    <= length_in;
         kind_ff      <= kind_in;
         matching_ff  <= matching_in;
         class_ok_ff  <= class_ok_in;
         ep_bulk_ff   <= ep_bulk_in;
         ep_addr_ff   <= ep_addr_in;
         pkt_low_ff   <= pkt_low_in;
         cand_ff      <= cand_in;
         stopped_ff   <= stopped_in;
         malformed_ff <= malformed_in;
      end
   end

endmodule
